// ===== rtl/core/sdvc_pkg.sv =====
package sdvc_pkg;

    localparam int LINE_COUNT     = 16;
    localparam int WORDS_PER_LINE = 4;
    localparam int LINE_BITS      = $clog2(LINE_COUNT);
    localparam int WORD_BITS      = $clog2(WORDS_PER_LINE);
    localparam int DATA_DEPTH     = LINE_COUNT * WORDS_PER_LINE;
    localparam int DIDX_W         = LINE_BITS + WORD_BITS;
    localparam int ADDR_TAG_W     = 24;
    localparam int FC_W           = 3;
    localparam int TAG_W          = ADDR_TAG_W + FC_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 1;

    typedef enum logic [2:0] {
        MODE_READ        = 3'd0,
        MODE_FILL        = 3'd1,
        MODE_WRITE       = 3'd2,
        MODE_CLEAR_ALL   = 3'd3,
        MODE_CLEAR_ENTRY = 3'd4
    } mode_e;

    typedef enum logic [1:0] {
        WS_HIT       = 2'd0,
        WS_UNTOUCHED = 2'd1,
        WS_ALLOC     = 2'd2,
        WS_INVAL     = 2'd3
    } wstat_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CACHE_ENABLE = 2'd0,
        CFG_FREEZE       = 2'd1,
        CFG_WR_ALLOC     = 2'd2,
        CFG_BURST_FILL   = 2'd3
    } cfg_idx_e;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] address;
        logic [2:0]  fcode;
        logic [31:0] word_value;
        logic        aligned_long;
        logic        bypass;
        logic        locked_cycle;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_data;
        logic        burst_request;
        logic [1:0]  write_status;
    } rsp_t;

    typedef struct packed {
        logic cache_enable;
        logic freeze;
        logic wr_alloc;
        logic burst_fill;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [DIDX_W-1:0] addr;
        logic [31:0]       data;
    } dwr_t;

endpackage

// ===== rtl/core/sdvc_data_ram.sv =====
module sdvc_data_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [sdvc_pkg::DIDX_W-1:0] waddr,
    input  logic [31:0]                wdata,
    input  logic [sdvc_pkg::DIDX_W-1:0] raddr,
    output logic [31:0]                rdata
);
    import sdvc_pkg::*;

    logic [31:0] mem [DATA_DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sdvc_lookup.sv =====
module sdvc_lookup (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           act,
    input  sdvc_pkg::req_t req,
    input  sdvc_pkg::cfg_t cfg,
    input  logic [31:0]    rd_word,
    output sdvc_pkg::dwr_t dwr,
    output sdvc_pkg::rsp_t rsp_next
);
    import sdvc_pkg::*;

    logic [TAG_W-1:0]          tag_reg   [LINE_COUNT];
    logic [WORDS_PER_LINE-1:0] valid_reg [LINE_COUNT];

    logic [LINE_BITS-1:0]      li;
    logic [WORD_BITS-1:0]      wi;
    logic [TAG_W-1:0]          tag;
    logic [WORDS_PER_LINE-1:0] wbit;
    logic [WORDS_PER_LINE-1:0] vline;
    logic [WORDS_PER_LINE-1:0] vline_next;
    logic                      tag_hit;
    logic                      word_valid;
    logic                      en;
    logic                      tag_wr;
    logic                      clear_all;

    assign li         = req.address[LINE_BITS+WORD_BITS+1:WORD_BITS+2];
    assign wi         = req.address[WORD_BITS+1:2];
    assign tag        = {req.fcode, req.address[31:32-ADDR_TAG_W]};
    assign wbit       = {{(WORDS_PER_LINE-1){1'b0}}, 1'b1} << wi;
    assign vline      = valid_reg[li];
    assign tag_hit    = (tag_reg[li] == tag);
    assign word_valid = |(vline & wbit);
    assign en         = cfg.cache_enable && !req.bypass;

    always_comb
    begin
        rsp_next   = '0;
        dwr.we     = 1'b0;
        dwr.addr   = {li, wi};
        dwr.data   = req.word_value;
        tag_wr     = 1'b0;
        clear_all  = 1'b0;
        vline_next = vline;
        if (act)
        begin
            unique case (req.mode)
                MODE_READ:
                begin
                    if (en && tag_hit && word_valid)
                    begin
                        rsp_next.hit       = 1'b1;
                        rsp_next.read_data = rd_word;
                    end
                    else if (en && cfg.burst_fill && !cfg.freeze && !req.locked_cycle
                             && (!tag_hit || vline == '0))
                    begin
                        rsp_next.burst_request = 1'b1;
                    end
                end
                MODE_FILL:
                begin
                    if (en && !cfg.freeze)
                    begin
                        dwr.we = 1'b1;
                        if (!tag_hit)
                        begin
                            tag_wr     = 1'b1;
                            vline_next = wbit;
                        end
                        else
                        begin
                            vline_next = vline | wbit;
                        end
                    end
                end
                MODE_WRITE:
                begin
                    priority if (!en)
                    begin
                        rsp_next.write_status = WS_UNTOUCHED;
                    end
                    else if (tag_hit && word_valid)
                    begin
                        dwr.we                = 1'b1;
                        rsp_next.write_status = WS_HIT;
                    end
                    else if (cfg.freeze || !cfg.wr_alloc)
                    begin
                        rsp_next.write_status = WS_UNTOUCHED;
                    end
                    else if (req.aligned_long)
                    begin
                        dwr.we                = 1'b1;
                        tag_wr                = 1'b1;
                        vline_next            = wbit;
                        rsp_next.write_status = WS_ALLOC;
                    end
                    else
                    begin
                        vline_next            = vline & ~wbit;
                        rsp_next.write_status = WS_INVAL;
                    end
                end
                MODE_CLEAR_ALL:
                begin
                    clear_all = 1'b1;
                end
                MODE_CLEAR_ENTRY:
                begin
                    vline_next = vline & ~wbit;
                end
                default:
                begin
                    vline_next = vline;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                tag_reg[i]   <= '0;
                valid_reg[i] <= '0;
            end
        end
        else if (clear_all)
        begin
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                valid_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg[li] <= vline_next;
            if (tag_wr)
            begin
                tag_reg[li] <= tag;
            end
        end
    end

endmodule

// ===== rtl/core/subblock_valid_direct_cache.sv =====
// Direct-mapped cache, 16 lines of four long words, per-word valid bits,
// write-through. One transaction is taken on every clock (busy never rises).
// Each transaction passes through the input register, loaded together with the data
// RAM's registered read port, and then the result register, loaded as the tag
// compare updates the tag and valid state; rsp and done come from the result register,
// with done high for a single cycle per result. The receiver cannot stall, so done must
// be sampled when it is high. A write or fill followed straight away by a read of the
// same word is forwarded around the RAM. Configuration writes take effect at once
// and belong in idle time.
module subblock_valid_direct_cache (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sdvc_pkg::req_t                 req,
    output logic                           done,
    output sdvc_pkg::rsp_t                 rsp,
    input  logic                           cfg_we,
    input  logic [sdvc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sdvc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sdvc_pkg::*;

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic        fwd_hit_reg;
    logic [31:0] fwd_data_reg;
    logic        done_reg;
    rsp_t        rsp_reg;

    logic        accept;
    logic [31:0] ram_rdata;
    logic [31:0] rd_word;
    dwr_t        dwr;
    rsp_t        rsp_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CACHE_ENABLE: cfg_reg.cache_enable <= cfg_data[0];
                CFG_FREEZE:       cfg_reg.freeze       <= cfg_data[0];
                CFG_WR_ALLOC:     cfg_reg.wr_alloc     <= cfg_data[0];
                CFG_BURST_FILL:   cfg_reg.burst_fill   <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            // the RAM read this cycle misses the write landing on the same edge
            fwd_hit_reg  <= dwr.we && (dwr.addr == req.address[DIDX_W+1:2]);
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
        fwd_data_reg <= dwr.data;
        rsp_reg      <= rsp_next;
    end

    sdvc_data_ram u_data_ram (
        .clk   (clk),
        .we    (dwr.we),
        .waddr (dwr.addr),
        .wdata (dwr.data),
        .raddr (req.address[DIDX_W+1:2]),
        .rdata (ram_rdata)
    );

    assign rd_word = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    sdvc_lookup u_lookup (
        .clk      (clk),
        .rst_n    (rst_n),
        .act      (s1_valid_reg),
        .req      (s1_req_reg),
        .cfg      (cfg_reg),
        .rd_word  (rd_word),
        .dwr      (dwr),
        .rsp_next (rsp_next)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTH
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted transaction gave no result two cycles later");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> done)
        else $error("stage one transaction lost before the result register");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> (!rsp.burst_request && rsp.write_status == WS_HIT))
        else $error("read hit carries burst request or write status");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |=> (rsp.hit == 1'b0 && rsp.burst_request == 1'b0))
        else $error("result fields set without a transaction");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import sdvc_pkg::*;

    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES     = 4;
    localparam int         REPORT_MAX       = 10;
    localparam int         PHASE_COUNT      = 7;
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  req;
    logic                  done;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow copy of the cache contents and control bits
    logic [TAG_W-1:0]          tag_store  [LINE_COUNT];
    logic [WORDS_PER_LINE-1:0] word_valid [LINE_COUNT];
    logic [31:0]               word_store [DATA_DEPTH];
    cfg_t                      cfg_shadow;

    // tags (function code in the top bits) that random traffic keeps reusing
    logic [TAG_W-1:0] tag_pool [4];

    rsp_t pending_rsp [$];
    int   mismatches;
    int   accepted;
    int   settings_run;
    int   read_hits;
    int   burst_reqs;
    int   allocs;
    int   invals;
    int   untouched;
    int   quiet_cycles;
    int   stretch_left;
    bit   idle_allowed;
    bit   idle_off;

    subblock_valid_direct_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_t lookup_cache(input req_t r);
        logic [LINE_BITS-1:0] li;
        logic [WORD_BITS-1:0] wi;
        logic [DIDX_W-1:0]    di;
        logic [TAG_W-1:0]     tag;
        logic                 tag_match;
        logic                 word_ok;
        logic                 active;
        rsp_t                 o;
        li        = r.address[7:4];
        wi        = r.address[3:2];
        di        = {li, wi};
        tag       = {r.fcode, r.address[31:8]};
        tag_match = (tag_store[li] == tag);
        word_ok   = word_valid[li][wi];
        active    = cfg_shadow.cache_enable && !r.bypass;
        o         = '0;
        case (r.mode)
            MODE_READ:
            begin
                if (active && tag_match && word_ok)
                begin
                    o.hit       = 1'b1;
                    o.read_data = word_store[di];
                end
                else if (active && cfg_shadow.burst_fill && !cfg_shadow.freeze &&
                         !r.locked_cycle)
                begin
                    o.burst_request = !tag_match || (word_valid[li] == '0);
                end
            end
            MODE_FILL:
            begin
                if (active && !cfg_shadow.freeze)
                begin
                    if (!tag_match)
                    begin
                        word_valid[li] = '0;
                        tag_store[li]  = tag;
                    end
                    word_store[di]     = r.word_value;
                    word_valid[li][wi] = 1'b1;
                end
            end
            MODE_WRITE:
            begin
                if (!active)
                    o.write_status = WS_UNTOUCHED;
                else if (tag_match && word_ok)
                begin
                    word_store[di] = r.word_value;
                    o.write_status = WS_HIT;
                end
                else if (cfg_shadow.freeze || !cfg_shadow.wr_alloc)
                    o.write_status = WS_UNTOUCHED;
                else if (r.aligned_long)
                begin
                    tag_store[li]      = tag;
                    word_store[di]     = r.word_value;
                    word_valid[li]     = '0;
                    word_valid[li][wi] = 1'b1;
                    o.write_status     = WS_ALLOC;
                end
                else
                begin
                    word_valid[li][wi] = 1'b0;
                    o.write_status     = WS_INVAL;
                end
            end
            MODE_CLEAR_ALL:
            begin
                foreach (word_valid[i])
                    word_valid[i] = '0;
            end
            MODE_CLEAR_ENTRY:
                word_valid[li][wi] = 1'b0;
            default: ;
        endcase
        return o;
    endfunction

    function automatic req_t make_access(input logic [2:0] mode, input logic [31:0] address,
                                         input logic [2:0] fc, input logic [31:0] value,
                                         input logic aligned, input logic bypass,
                                         input logic locked);
        req_t r;
        r.mode          = mode;
        r.address       = address;
        r.fcode         = fc;
        r.word_value    = value;
        r.aligned_long  = aligned;
        r.bypass        = bypass;
        r.locked_cycle  = locked;
        return r;
    endfunction

    // mostly the first pool tag so that lines stay resident long enough to hit
    function automatic int pick_tag();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic req_t random_access();
        req_t r;
        int   p;
        int   k;
        p = $urandom_range(0, 99);
        if (p < 40)
            r.mode = MODE_READ;
        else if (p < 65)
            r.mode = MODE_FILL;
        else if (p < 90)
            r.mode = MODE_WRITE;
        else if (p < 96)
            r.mode = MODE_CLEAR_ENTRY;
        else if (p < 97)
            r.mode = MODE_CLEAR_ALL;
        else
            r.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        if ($urandom_range(0, 9) == 0)
        begin
            r.address = $urandom;
            r.fcode   = 3'($urandom);
        end
        else
        begin
            k         = pick_tag();
            r.address = {tag_pool[k][23:0], 8'($urandom)};
            r.fcode   = tag_pool[k][26:24];
        end
        r.word_value   = $urandom;
        r.aligned_long = ($urandom_range(0, 9) < 7);
        r.bypass       = ($urandom_range(0, 9) == 0);
        r.locked_cycle = ($urandom_range(0, 6) == 0);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic send_access(input req_t r);
        rsp_t e;
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        e = lookup_cache(r);
        pending_rsp.push_back(e);
        accepted++;
        if (e.hit)
            read_hits++;
        if (e.burst_request)
            burst_reqs++;
        if (r.mode == MODE_WRITE)
        begin
            if (e.write_status == WS_ALLOC)
                allocs++;
            else if (e.write_status == WS_INVAL)
                invals++;
            else if (e.write_status == WS_UNTOUCHED)
                untouched++;
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // random gaps, switched on and off in stretches
    task automatic maybe_idle();
        if (stretch_left == 0)
        begin
            idle_allowed = ($urandom_range(0, 2) != 0);
            stretch_left = $urandom_range(20, 80);
        end
        stretch_left--;
        if (!idle_off && idle_allowed && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(posedge clk);
        end
    endtask

    // one register per cycle, only with nothing in flight
    task automatic apply_config(input cfg_t c);
        cfg_idx_e idx;
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_idx_e'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_CACHE_ENABLE: cfg_data <= c.cache_enable;
                CFG_FREEZE:       cfg_data <= c.freeze;
                CFG_WR_ALLOC:     cfg_data <= c.wr_alloc;
                CFG_BURST_FILL:   cfg_data <= c.burst_fill;
                default: ;
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cfg_shadow = c;
        settings_run++;
        @(posedge clk);
    endtask

    // a read, four word fills, then reads and writes around the same line
    task automatic send_line_sequence();
        req_t       r;
        int         k;
        logic [3:0] line;
        k    = pick_tag();
        line = 4'($urandom);
        r    = make_access(MODE_READ, {tag_pool[k][23:0], line, 4'($urandom)},
                           tag_pool[k][26:24], $urandom, 1'b1, 1'b0, 1'b0);
        send_access(r);
        maybe_idle();
        for (int w = 0; w < WORDS_PER_LINE; w++)
        begin
            r.mode         = MODE_FILL;
            r.address[3:0] = {2'(w), 2'($urandom)};
            r.word_value   = $urandom;
            r.bypass       = ($urandom_range(0, 19) == 0);
            send_access(r);
            maybe_idle();
        end
        repeat ($urandom_range(2, 5))
        begin
            r.mode           = ($urandom_range(0, 3) == 0) ? MODE_WRITE : MODE_READ;
            r.address[3:0]   = 4'($urandom);
            r.word_value     = $urandom;
            r.aligned_long   = ($urandom_range(0, 3) != 0);
            r.bypass         = ($urandom_range(0, 19) == 0);
            r.locked_cycle   = ($urandom_range(0, 9) == 0);
            send_access(r);
            maybe_idle();
        end
    endtask

    task automatic test_reset_defaults();
        send_access(make_access(MODE_READ, 32'h0, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_WRITE, 32'h0, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
    endtask

    task automatic test_directed_lookups();
        apply_config(4'b1011);  // enable, no freeze, allocate, burst
        send_access(make_access(MODE_READ, 32'hFFFF_FFFC, 3'd7, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_FILL, 32'hFFFF_FFFC, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b0,
                                1'b0));
        // straight after the fill: exercises the forwarding path
        send_access(make_access(MODE_READ, 32'hFFFF_FFFC, 3'd7, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_READ, 32'hFFFF_FFF0, 3'd7, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_READ, 32'h0000_00F0, 3'd0, 32'h0, 1'b0, 1'b0, 1'b1));
        send_access(make_access(MODE_READ, 32'hFFFF_FFFC, 3'd7, 32'h0, 1'b0, 1'b1, 1'b0));
        send_access(make_access(MODE_WRITE, 32'hFFFF_FFFC, 3'd7, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_WRITE, 32'h1234_5670, 3'd3, 32'hA5A5_5A5A, 1'b1, 1'b0,
                                1'b0));
        send_access(make_access(MODE_WRITE, 32'hABCD_EF78, 3'd0, 32'h5A5A_A5A5, 1'b0, 1'b0,
                                1'b0));
        send_access(make_access(MODE_READ, 32'h1234_5670, 3'd3, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_CLEAR_ENTRY, 32'h1234_5670, 3'd3, 32'h0, 1'b0, 1'b0,
                                1'b0));
        send_access(make_access(MODE_READ, 32'h1234_5670, 3'd3, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_WRITE, 32'h1234_5670, 3'd3, 32'h1, 1'b1, 1'b1, 1'b0));
        send_access(make_access(MODE_SPARE_FIRST, $urandom, 3'($urandom), $urandom, 1'b1,
                                1'b0, 1'b1));
        send_access(make_access(MODE_SPARE_LAST, $urandom, 3'($urandom), $urandom, 1'b1,
                                1'b1, 1'b1));
        send_access(make_access(MODE_CLEAR_ALL, 32'h0, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_READ, 32'hFFFF_FFFC, 3'd7, 32'h0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_freeze();
        send_access(make_access(MODE_FILL, 32'h0000_0040, 3'd1, 32'h1111_2222, 1'b1, 1'b0,
                                1'b0));
        apply_config(4'b1111);
        send_access(make_access(MODE_WRITE, 32'h0000_0040, 3'd1, 32'h3333_4444, 1'b0, 1'b0,
                                1'b0));
        send_access(make_access(MODE_WRITE, 32'h0000_0080, 3'd1, 32'h5555_6666, 1'b1, 1'b0,
                                1'b0));
        send_access(make_access(MODE_FILL, 32'h0000_0080, 3'd1, 32'h7777_8888, 1'b1, 1'b0,
                                1'b0));
        send_access(make_access(MODE_READ, 32'h0000_0080, 3'd1, 32'h0, 1'b0, 1'b0, 1'b0));
        send_access(make_access(MODE_READ, 32'h0000_0040, 3'd1, 32'h0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic(input int target);
        cfg_t settings [PHASE_COUNT];
        int   goal;
        // {cache_enable, freeze, wr_alloc, burst_fill}
        settings[0] = 4'b1011;
        settings[1] = 4'b1111;
        settings[2] = 4'b1001;
        settings[3] = 4'b0000;
        settings[4] = 4'b1110;
        settings[5] = cfg_t'(4'($urandom));
        settings[6] = 4'b1010;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            apply_config(settings[p]);
            goal = accepted + target / PHASE_COUNT;
            while (accepted < goal)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_line_sequence();
                else
                    send_access(random_access());
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                else
                    maybe_idle();
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        apply_config(4'b1011);
        idle_off = 1'b1;
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                send_line_sequence();
            else
                send_access(random_access());
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rsp_t e;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
                note_mismatch($sformatf("result with nothing expected: %p", rsp));
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.hit !== e.hit || rsp.read_data !== e.read_data ||
                    rsp.burst_request !== e.burst_request ||
                    rsp.write_status !== e.write_status)
                    note_mismatch($sformatf(
                        "hit %b/%b data %h/%h burst %b/%b wstat %0d/%0d (exp/act)",
                        e.hit, rsp.hit, e.read_data, rsp.read_data,
                        e.burst_request, rsp.burst_request,
                        e.write_status, rsp.write_status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cfg_shadow   = '0;
        mismatches   = 0;
        accepted     = 0;
        settings_run = 0;
        read_hits    = 0;
        burst_reqs   = 0;
        allocs       = 0;
        invals       = 0;
        untouched    = 0;
        quiet_cycles = 0;
        stretch_left = 0;
        idle_allowed = 1'b0;
        idle_off     = 1'b0;
        foreach (tag_store[i])
        begin
            tag_store[i]  = '0;
            word_valid[i] = '0;
        end
        foreach (word_store[i])
            word_store[i] = '0;
        tag_pool[0] = {3'd0, 24'h00_0000};
        tag_pool[1] = {3'd7, 24'hFF_FFFF};
        tag_pool[2] = {3'($urandom), 24'($urandom)};
        tag_pool[3] = {3'($urandom), 24'($urandom)};

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_lookups();
        test_freeze();
        test_random_traffic(1150);
        test_back_to_back(80);

        wait_drained();
        repeat (DRAIN_CYCLES * 2)
            @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_rsp.size());
            mismatches += pending_rsp.size();
        end

        $display("covered %0d transactions over %0d cache settings", accepted, settings_run);
        $display("read hits %0d, burst requests %0d, allocations %0d, invalidations %0d, %s %0d",
                 read_hits, burst_reqs, allocs, invals, "untouched writes", untouched);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
